// ===== hdl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the typed swap-remove slot table
// sizes, record layouts, status codes and the control/memory request bundles
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int NUM_KINDS     = 5;
  localparam int MAX_PER_KIND  = 1024;
  localparam int MAX_INSTANCES = 4096;

  localparam int KIND_W  = 3;
  localparam int SLOT_W  = $clog2(MAX_PER_KIND);
  localparam int INST_W  = $clog2(MAX_INSTANCES);
  localparam int OWNER_W = 32;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int ICNT_W  = INST_W + 1;

  // entry record: {instance position, owner id}
  localparam int ENTRY_W     = INST_W + OWNER_W;
  localparam int ENTRY_DEPTH = NUM_KINDS * MAX_PER_KIND;
  localparam int ENTRY_AW    = KIND_W + SLOT_W;

  // instance record: {kind, per-kind index}
  localparam int IREC_W = KIND_W + SLOT_W;

  localparam logic [ENTRY_W-1:0] MASK_ALL  = {ENTRY_W{1'b1}};
  localparam logic [ENTRY_W-1:0] MASK_INST = {{INST_W{1'b1}}, {OWNER_W{1'b0}}};

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [OWNER_W-1:0] owner;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  a_idx;
    logic [INST_W-1:0]  a_inst;
    logic               moved;
    logic [OWNER_W-1:0] mv_owner;
    logic [SLOT_W-1:0]  mv_idx;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [ENTRY_AW-1:0] waddr;
    logic [ENTRY_W-1:0]  wmask;
    logic [ENTRY_W-1:0]  wdata;
    logic [ENTRY_AW-1:0] raddr;
  } entry_req_t;

  typedef struct packed {
    logic              we;
    logic [INST_W-1:0] waddr;
    logic [IREC_W-1:0] wdata;
    logic [INST_W-1:0] raddr;
  } inst_req_t;

endpackage

// ===== hdl/tsr_ram.sv =====
// ----------------------------------------------------------------------------
// tsr_ram: simple dual-port synchronous ram
// one write port with a bit mask, one read port with registered data
// ----------------------------------------------------------------------------
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wmask,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsr_ctrl: sequencer of the slot table
// holds the counts, drives both memories and registers the result
// ----------------------------------------------------------------------------
module tsr_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tsr_pkg::item_t                  in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tsr_pkg::result_t                out_res,
  output tsr_pkg::entry_req_t             entry_req,
  input  logic [tsr_pkg::ENTRY_W-1:0]     entry_rdata,
  output tsr_pkg::inst_req_t              inst_req,
  input  logic [tsr_pkg::IREC_W-1:0]      inst_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_SRC,
    S_MOVE,
    S_DROP,
    S_DONE
  } state_t;

  state_t state;

  logic [tsr_pkg::CNT_W-1:0]   cnt [tsr_pkg::NUM_KINDS];
  logic [tsr_pkg::ICNT_W-1:0]  icount;

  logic [tsr_pkg::KIND_W-1:0]  kind_r;
  logic [tsr_pkg::SLOT_W-1:0]  slot_r;
  logic [tsr_pkg::SLOT_W-1:0]  last_r;
  logic [tsr_pkg::INST_W-1:0]  last_i_r;
  logic [tsr_pkg::INST_W-1:0]  pos_r;
  logic [tsr_pkg::KIND_W-1:0]  lk_r;
  logic [tsr_pkg::SLOT_W-1:0]  ls_r;
  tsr_pkg::result_t            res_r;

  logic                        in_fire;
  logic                        kind_ok;
  logic [tsr_pkg::CNT_W-1:0]   ccnt;
  logic [tsr_pkg::CNT_W-1:0]   ccnt_m1;
  logic [tsr_pkg::ICNT_W-1:0]  icount_m1;
  logic                        ins_ok;
  logic                        rem_ok;
  logic                        mv;
  logic [tsr_pkg::INST_W-1:0]  mp;
  logic                        drop_fix;
  tsr_pkg::result_t            res_idle;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign kind_ok   = ({1'b0, in_item.kind} < (tsr_pkg::KIND_W + 1)'(tsr_pkg::NUM_KINDS));
  assign ccnt      = kind_ok ? cnt[in_item.kind] : '0;
  assign ccnt_m1   = ccnt - tsr_pkg::CNT_W'(1);
  assign icount_m1 = icount - tsr_pkg::ICNT_W'(1);
  assign ins_ok    = kind_ok && (ccnt < tsr_pkg::CNT_W'(tsr_pkg::MAX_PER_KIND))
                     && (icount < tsr_pkg::ICNT_W'(tsr_pkg::MAX_INSTANCES));
  assign rem_ok    = kind_ok && ({1'b0, in_item.slot} < ccnt);
  assign mv        = (slot_r != last_r);
  assign mp        = entry_rdata[tsr_pkg::ENTRY_W-1 -: tsr_pkg::INST_W];
  assign drop_fix  = (pos_r < last_i_r)
                     && ({1'b0, lk_r} < (tsr_pkg::KIND_W + 1)'(tsr_pkg::NUM_KINDS));

  // result of an insert or an error, decided at acceptance
  always_comb begin
    res_idle          = '0;
    res_idle.mv_owner = '1;
    res_idle.mv_idx   = '1;
    if (in_item.mode == tsr_pkg::MODE_INSERT) begin
      if (ins_ok) begin
        res_idle.status = tsr_pkg::ST_OK;
        res_idle.a_idx  = ccnt[tsr_pkg::SLOT_W-1:0];
        res_idle.a_inst = icount[tsr_pkg::INST_W-1:0];
      end else begin
        res_idle.status = tsr_pkg::ST_FULL;
      end
    end else begin
      res_idle.status = rem_ok ? tsr_pkg::ST_OK : tsr_pkg::ST_RANGE;
    end
  end

  // memory requests
  always_comb begin
    entry_req       = '0;
    inst_req        = '0;
    entry_req.raddr = {in_item.kind, in_item.slot};
    inst_req.raddr  = icount_m1[tsr_pkg::INST_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_fire && in_item.mode == tsr_pkg::MODE_INSERT && ins_ok) begin
          entry_req.we    = 1'b1;
          entry_req.waddr = {in_item.kind, ccnt[tsr_pkg::SLOT_W-1:0]};
          entry_req.wmask = tsr_pkg::MASK_ALL;
          entry_req.wdata = {icount[tsr_pkg::INST_W-1:0], in_item.owner};
          inst_req.we     = 1'b1;
          inst_req.waddr  = icount[tsr_pkg::INST_W-1:0];
          inst_req.wdata  = {in_item.kind, ccnt[tsr_pkg::SLOT_W-1:0]};
        end
      end
      S_RD_SRC: begin
        entry_req.raddr = {kind_r, last_r};
      end
      S_MOVE: begin
        // last entry of the kind fills the hole, its instance points back
        if (mv) begin
          entry_req.we    = 1'b1;
          entry_req.waddr = {kind_r, slot_r};
          entry_req.wmask = tsr_pkg::MASK_ALL;
          entry_req.wdata = entry_rdata;
          inst_req.we     = 1'b1;
          inst_req.waddr  = mp;
          inst_req.wdata  = {kind_r, slot_r};
        end
      end
      S_DROP: begin
        // last instance fills the freed position, its entry points back
        if (drop_fix) begin
          entry_req.we    = 1'b1;
          entry_req.waddr = {lk_r, ls_r};
          entry_req.wmask = tsr_pkg::MASK_INST;
          entry_req.wdata = {pos_r, {tsr_pkg::OWNER_W{1'b0}}};
          inst_req.we     = 1'b1;
          inst_req.waddr  = pos_r;
          inst_req.wdata  = {lk_r, ls_r};
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      icount    <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < tsr_pkg::NUM_KINDS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            kind_r   <= in_item.kind;
            slot_r   <= in_item.slot;
            last_r   <= ccnt_m1[tsr_pkg::SLOT_W-1:0];
            last_i_r <= icount_m1[tsr_pkg::INST_W-1:0];
            res_r    <= res_idle;
            if (in_item.mode == tsr_pkg::MODE_INSERT) begin
              if (ins_ok) begin
                cnt[in_item.kind] <= ccnt + tsr_pkg::CNT_W'(1);
                icount            <= icount + tsr_pkg::ICNT_W'(1);
              end
              state <= S_DONE;
            end else if (rem_ok) begin
              state <= S_RD_SRC;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD_SRC: begin
          pos_r <= entry_rdata[tsr_pkg::ENTRY_W-1 -: tsr_pkg::INST_W];
          lk_r  <= inst_rdata[tsr_pkg::IREC_W-1 -: tsr_pkg::KIND_W];
          ls_r  <= inst_rdata[tsr_pkg::SLOT_W-1:0];
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (mv) begin
            res_r.moved    <= 1'b1;
            res_r.mv_owner <= entry_rdata[tsr_pkg::OWNER_W-1:0];
            res_r.mv_idx   <= slot_r;
            // forward the slot just written into the last instance record
            if (mp == last_i_r) begin
              ls_r <= slot_r;
            end
          end
          state <= S_DROP;
        end
        S_DROP: begin
          cnt[kind_r] <= cnt[kind_r] - tsr_pkg::CNT_W'(1);
          if (icount != '0) begin
            icount <= icount_m1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_res   <= res_r;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_icount_bound: assert property (@(posedge clk) disable iff (rst)
    icount <= tsr_pkg::ICNT_W'(tsr_pkg::MAX_INSTANCES))
    else $error("instance count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.mode == tsr_pkg::MODE_INSERT && ins_ok)
    |=> (icount == $past(icount) + tsr_pkg::ICNT_W'(1)))
    else $error("insert did not grow the instance list");

  a_drop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP && icount != '0) |=> (icount == $past(icount_m1)))
    else $error("remove did not shrink the instance list");

  a_no_write_idle_phases: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_SRC || state == S_DONE) |-> (!entry_req.we && !inst_req.we))
    else $error("memory write outside an update phase");

endmodule

// ===== hdl/typed_swap_remove_slot_table.sv =====
// ----------------------------------------------------------------------------
// typed_swap_remove_slot_table: per-kind dense lists cross-linked with a
// dense instance list, insert appends, remove swap-pops both lists
// ----------------------------------------------------------------------------
//
//  channel  | direction | transaction
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one insert or remove request
//  m_axis   | out       | one result per request (status, indices, moved owner)
//
//  insert and any rejected request: accepted in S_IDLE, the result registered
//  in S_DONE, then the next request taken in S_IDLE; a remove passes through
//  S_RD_SRC, S_MOVE, S_DROP and S_DONE, as set by the entry memory's single
//  read port: the hole's record and then the kind's last record are read one
//  after the other, then the move and the instance swap-pop are written back.
//  rst (synchronous) clears state, m_axis_tvalid, per-kind and instance counts;
//  the memories need no clearing since nothing below a count is unwritten.
//  a new request is taken once the previous one has its result registered;
//  a stalled m_axis holds one result and lets the next request run up to it.
//
module typed_swap_remove_slot_table (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // slot_index[9:0], owner_id[41:10], zero pad
  input  logic [3:0]  s_axis_tuser,   // mode[0], light_kind[3:1]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // assigned_index[9:0], assigned_instance[21:10],
                                      // moved[22], moved_owner_id[54:23],
                                      // moved_new_index[64:55], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  tsr_pkg::item_t                   in_item;
  tsr_pkg::result_t                 out_res;
  tsr_pkg::entry_req_t              entry_req;
  tsr_pkg::inst_req_t               inst_req;
  logic [tsr_pkg::ENTRY_W-1:0]      entry_rdata;
  logic [tsr_pkg::IREC_W-1:0]       inst_rdata;

  // unpack the request
  assign in_item.mode  = s_axis_tuser[0];
  assign in_item.kind  = s_axis_tuser[3:1];
  assign in_item.slot  = s_axis_tdata[9:0];
  assign in_item.owner = s_axis_tdata[41:10];

  // sequencer: counts, memory requests and result register
  tsr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (out_res),
    .entry_req   (entry_req),
    .entry_rdata (entry_rdata),
    .inst_req    (inst_req),
    .inst_rdata  (inst_rdata)
  );

  // per-kind entry lists, kind in the upper address bits
  tsr_ram #(
    .WIDTH (tsr_pkg::ENTRY_W),
    .DEPTH (tsr_pkg::ENTRY_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_req.we),
    .waddr (entry_req.waddr),
    .wmask (entry_req.wmask),
    .wdata (entry_req.wdata),
    .raddr (entry_req.raddr),
    .rdata (entry_rdata)
  );

  // dense instance list, always written as whole records
  tsr_ram #(
    .WIDTH (tsr_pkg::IREC_W),
    .DEPTH (tsr_pkg::MAX_INSTANCES)
  ) u_inst_ram (
    .clk   (clk),
    .we    (inst_req.we),
    .waddr (inst_req.waddr),
    .wmask ({tsr_pkg::IREC_W{1'b1}}),
    .wdata (inst_req.wdata),
    .raddr (inst_req.raddr),
    .rdata (inst_rdata)
  );

  // pack the result
  assign m_axis_tuser         = out_res.status;
  assign m_axis_tdata[9:0]    = out_res.a_idx;
  assign m_axis_tdata[21:10]  = out_res.a_inst;
  assign m_axis_tdata[22]     = out_res.moved;
  assign m_axis_tdata[54:23]  = out_res.mv_owner;
  assign m_axis_tdata[64:55]  = out_res.mv_idx;
  assign m_axis_tdata[71:65]  = '0;

endmodule

// ===== dv/slot_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_checker: result predictor and comparator for the slot table
// mirrors the per-kind lists and the instance list, predicts one result per
// accepted request and compares it field by field with the next result
// ----------------------------------------------------------------------------
module slot_table_checker
  import tsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // slot_index[9:0], owner_id[41:10], zero pad
  input  logic [3:0]  s_axis_tuser,   // mode[0], light_kind[3:1]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,   // assigned_index[9:0], assigned_instance[21:10],
                                      // moved[22], moved_owner_id[54:23],
                                      // moved_new_index[64:55], zero pad
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  output int          fail_count,
  output int          pending
);

  // mirrored table contents
  logic [INST_W-1:0]  entry_pos   [NUM_KINDS][MAX_PER_KIND];
  logic [OWNER_W-1:0] entry_owner [NUM_KINDS][MAX_PER_KIND];
  logic [CNT_W-1:0]   kind_fill   [NUM_KINDS];
  logic [KIND_W-1:0]  inst_kind   [MAX_INSTANCES];
  logic [SLOT_W-1:0]  inst_slot   [MAX_INSTANCES];
  logic [ICNT_W-1:0]  inst_total;

  result_t queued_outcomes [$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // applies one request to the mirror and returns the result it must give
  function automatic result_t table_update(input item_t req);
    result_t           res;
    logic [SLOT_W-1:0] last_slot;
    logic [INST_W-1:0] hole_pos;
    logic [INST_W-1:0] moved_pos;
    logic [INST_W-1:0] last_pos;
    logic [KIND_W-1:0] tail_kind;
    logic [SLOT_W-1:0] tail_slot;
    res.status   = ST_OK;
    res.a_idx    = '0;
    res.a_inst   = '0;
    res.moved    = 1'b0;
    res.mv_owner = '1;
    res.mv_idx   = '1;
    if (req.mode == MODE_INSERT) begin
      if (req.kind >= NUM_KINDS || kind_fill[req.kind] >= MAX_PER_KIND ||
          inst_total >= MAX_INSTANCES) begin
        res.status = ST_FULL;
      end else begin
        res.a_idx  = kind_fill[req.kind][SLOT_W-1:0];
        res.a_inst = inst_total[INST_W-1:0];
        entry_pos[req.kind][res.a_idx]   = res.a_inst;
        entry_owner[req.kind][res.a_idx] = req.owner;
        inst_kind[res.a_inst] = req.kind;
        inst_slot[res.a_inst] = res.a_idx;
        kind_fill[req.kind] = kind_fill[req.kind] + 1'b1;
        inst_total = inst_total + 1'b1;
      end
    end else if (req.kind >= NUM_KINDS || req.slot >= kind_fill[req.kind]) begin
      res.status = ST_RANGE;
    end else begin
      last_slot = SLOT_W'(kind_fill[req.kind] - 1'b1);
      hole_pos  = entry_pos[req.kind][req.slot];
      // fill the hole with the kind's last entry and repoint its instance
      if (req.slot != last_slot) begin
        moved_pos = entry_pos[req.kind][last_slot];
        entry_pos[req.kind][req.slot]   = moved_pos;
        entry_owner[req.kind][req.slot] = entry_owner[req.kind][last_slot];
        inst_slot[moved_pos] = req.slot;
        res.moved    = 1'b1;
        res.mv_owner = entry_owner[req.kind][req.slot];
        res.mv_idx   = req.slot;
      end
      kind_fill[req.kind] = kind_fill[req.kind] - 1'b1;
      // swap-pop the instance list, then fix the entry that owned the tail
      last_pos = INST_W'(inst_total - 1'b1);
      if (hole_pos < last_pos) begin
        tail_kind = inst_kind[last_pos];
        tail_slot = inst_slot[last_pos];
        entry_pos[tail_kind][tail_slot] = hole_pos;
        inst_kind[hole_pos] = tail_kind;
        inst_slot[hole_pos] = tail_slot;
      end
      inst_total = inst_total - 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    item_t   req;
    if (rst) begin
      for (int k = 0; k < NUM_KINDS; k++) kind_fill[k] = '0;
      inst_total = '0;
      queued_outcomes.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status   = status_t'(m_axis_tuser);
        seen.a_idx    = m_axis_tdata[9:0];
        seen.a_inst   = m_axis_tdata[21:10];
        seen.moved    = m_axis_tdata[22];
        seen.mv_owner = m_axis_tdata[54:23];
        seen.mv_idx   = m_axis_tdata[64:55];
        if (queued_outcomes.size() == 0) begin
          flag_mismatch("unrequested result", m_axis_tdata[31:0], '0);
        end else begin
          want = queued_outcomes.pop_front();
          if (seen.status !== want.status)
            flag_mismatch("status", seen.status, want.status);
          if (seen.a_idx !== want.a_idx)
            flag_mismatch("assigned_index", seen.a_idx, want.a_idx);
          if (seen.a_inst !== want.a_inst)
            flag_mismatch("assigned_instance", seen.a_inst, want.a_inst);
          if (seen.moved !== want.moved)
            flag_mismatch("moved", seen.moved, want.moved);
          if (seen.mv_owner !== want.mv_owner)
            flag_mismatch("moved_owner_id", seen.mv_owner, want.mv_owner);
          if (seen.mv_idx !== want.mv_idx)
            flag_mismatch("moved_new_index", seen.mv_idx, want.mv_idx);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.mode  = s_axis_tuser[0];
        req.kind  = s_axis_tuser[3:1];
        req.slot  = s_axis_tdata[9:0];
        req.owner = s_axis_tdata[41:10];
        queued_outcomes.push_back(table_update(req));
      end
      pending <= queued_outcomes.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the typed swap-remove slot table
// drives directed corner requests, a random insert/remove mix and a full
// drain, with random gaps on both channels
// ----------------------------------------------------------------------------
module testbench;
  import tsr_pkg::*;

  // light kinds, plus two codes past the last valid one
  localparam logic [KIND_W-1:0] KIND_SPHERE        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPOT          = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AREA          = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISK          = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MESH          = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FIRST_UNKNOWN = KIND_W'(NUM_KINDS);
  localparam logic [KIND_W-1:0] KIND_TOP_CODE      = '1;

  localparam int RANDOM_REQUESTS = 800;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // slot_index[9:0], owner_id[41:10], zero pad
  logic [3:0]  s_axis_tuser  = '0;   // mode[0], light_kind[3:1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // assigned_index[9:0], assigned_instance[21:10],
                                     // moved[22], moved_owner_id[54:23],
                                     // moved_new_index[64:55], zero pad
  logic [1:0]  m_axis_tuser;         // status[1:0]

  int fail_count;
  int pending;

  // live entry counts, only used to steer the stimulus
  int unsigned live_per_kind [NUM_KINDS] = '{default: 0};
  int unsigned live_total = 0;

  // pacing state of the two channels
  bit send_calm  = 1'b0;
  bit take_calm  = 1'b0;
  int send_seq   = 0;
  int take_cycle = 0;
  int stall_left = 0;

  typed_swap_remove_slot_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  slot_table_checker table_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: mostly ready, short stalls, a few long ones, and periodically
  // a chance of a calm window with no new stalls, rolled from take_cycle
  always @(posedge clk) begin
    int roll;
    if (take_cycle % 256 == 0) take_calm = ($urandom_range(0, 3) == 0);
    take_cycle++;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (take_calm || roll < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_left = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      m_axis_tready <= 1'b0;
    end
  end

  // idle cycles before the next request; calm runs of 64 requests have none
  function automatic int idle_cycles();
    int roll;
    if (send_seq % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
    send_seq++;
    roll = $urandom_range(0, 99);
    if (send_calm || roll < 60) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // keeps the live counts in step with what the table accepts
  function automatic void track_live(input logic mode, input logic [KIND_W-1:0] kind,
                                     input logic [SLOT_W-1:0] slot);
    if (kind >= NUM_KINDS) return;
    if (mode == MODE_INSERT) begin
      if (live_per_kind[kind] < MAX_PER_KIND && live_total < MAX_INSTANCES) begin
        live_per_kind[kind]++;
        live_total++;
      end
    end else if (slot < live_per_kind[kind]) begin
      live_per_kind[kind]--;
      live_total--;
    end
  endfunction

  // slot for a remove: the last entry a quarter of the time, else any live one
  function automatic logic [SLOT_W-1:0] pick_slot(input logic [KIND_W-1:0] kind);
    if (live_per_kind[kind] == 0) return SLOT_W'($urandom);
    if ($urandom_range(0, 3) == 0) return SLOT_W'(live_per_kind[kind] - 1);
    return SLOT_W'($urandom_range(0, live_per_kind[kind] - 1));
  endfunction

  // one request transaction; valid stays high into the next request when
  // there is no gap, so it is never dropped and raised in the same step
  task automatic issue_request(input logic mode, input logic [KIND_W-1:0] kind,
                               input logic [SLOT_W-1:0] slot,
                               input logic [OWNER_W-1:0] owner);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, owner, slot};
    s_axis_tuser  <= {kind, mode};
    do @(posedge clk); while (!s_axis_tready);
    track_live(mode, kind, slot);
  endtask

  initial begin
    logic [KIND_W-1:0] kind;
    logic              mode;
    int                insert_pct;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corners: empty table, unknown kinds, range edges, moves
    issue_request(MODE_REMOVE, KIND_SPHERE, '0, '0);               // remove from empty
    issue_request(MODE_INSERT, KIND_SPHERE, '0, '0);
    issue_request(MODE_INSERT, KIND_SPHERE, '1, '1);
    issue_request(MODE_INSERT, KIND_SPOT, '0, 32'hA5A5_5A5A);
    issue_request(MODE_INSERT, KIND_AREA, '0, 32'h5A5A_A5A5);
    issue_request(MODE_INSERT, KIND_DISK, '0, 32'h0000_0001);
    issue_request(MODE_INSERT, KIND_MESH, '0, 32'h8000_0000);
    issue_request(MODE_INSERT, KIND_FIRST_UNKNOWN, '0, 32'hDEAD_BEEF);
    issue_request(MODE_INSERT, KIND_TOP_CODE, '1, '1);
    issue_request(MODE_REMOVE, KIND_FIRST_UNKNOWN, '0, '0);
    issue_request(MODE_REMOVE, KIND_TOP_CODE, '1, '1);
    issue_request(MODE_REMOVE, KIND_SPHERE, '1, '0);               // far out of range
    issue_request(MODE_REMOVE, KIND_SPHERE, SLOT_W'(2), '0);       // index equal to count
    issue_request(MODE_INSERT, KIND_SPHERE, '0, 32'h1234_5678);
    issue_request(MODE_REMOVE, KIND_SPHERE, '0, '0);               // last entry moves in
    issue_request(MODE_REMOVE, KIND_SPHERE, SLOT_W'(1), '0);       // removing the last one
    issue_request(MODE_REMOVE, KIND_MESH, '0, '0);                 // sole entry of a kind
    issue_request(MODE_REMOVE, KIND_SPOT, '0, '0);
    issue_request(MODE_INSERT, KIND_MESH, '0, 32'hFFFF_0000);
    issue_request(MODE_REMOVE, KIND_AREA, '0, '0);                 // instance swap-pop

    // random mix; counts hover around a few dozen per kind, a tenth is noise
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        issue_request(1'($urandom), KIND_W'($urandom), SLOT_W'($urandom), $urandom);
      end else begin
        kind       = KIND_W'($urandom_range(0, NUM_KINDS - 1));
        insert_pct = (live_per_kind[kind] < 40) ? 60 : 40;
        mode       = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
        issue_request(mode, kind, pick_slot(kind), $urandom);
      end
    end

    // drain everything with removes spread over the whole index range
    while (live_total > 0) begin
      kind = KIND_W'($urandom_range(0, NUM_KINDS - 1));
      if (live_per_kind[kind] > 0)
        issue_request(MODE_REMOVE, kind, pick_slot(kind), $urandom);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    // wait out longer than a remove takes; anything arriving after this is spurious
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // about 1100 requests with their worst gaps and stalls come to about 1.1 ms; allow 5 ms
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== typed_swap_remove_slot_table.f =====
hdl/tsr_pkg.sv
hdl/tsr_ram.sv
hdl/tsr_ctrl.sv
hdl/typed_swap_remove_slot_table.sv
dv/slot_table_checker.sv
dv/testbench.sv
